// ===== rtl/pbpr_pkg.sv =====
// package for the page buffer pool replacement block
// holds op codes for the top level and status codes shared with the checker
`timescale 1ns / 1ps
package pbpr_pkg;
	typedef enum logic [2:0] {
		OP_PIN     = 3'd0,
		OP_UNPIN   = 3'd1,
		OP_DIRTY   = 3'd2,
		OP_FORCE   = 3'd3,
		OP_FLUSH   = 3'd4,
		OP_INSPECT = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NOT_FOUND  = 2'd1,
		ST_NOT_PINNED = 2'd2,
		ST_ALL_PINNED = 2'd3
	} status_t;

	localparam int unsigned REG_FRAMES = 0;
	localparam int unsigned REG_POLICY = 1;
endpackage

// ===== rtl/page_buffer_pool_replacement_top.sv =====
// top level of the page buffer pool replacement block
// frame table in a synchronous memory walked by a sequencer; uses pbpr_pkg
// Usage: software drives op, page_number and frame_slot with start while busy
// is low; the item is taken at that edge and busy rises. Results come out on
// the result ports for one cycle each, marked by strobe; last marks the final
// result of an item. The receiver cannot stall, so results are never held.
// A pin, unpin, dirty, force or flush walks the frame memory one frame per
// cycle: a search pass over NUM_FRAMES frames, and for a pin that finds a
// page or a frame a second pass that updates the ranks. Busy is already low
// in the cycle of the last result, so start may take the next item at its
// end. Flush all gives one result per dirty frame (one plain result if none
// is dirty), each sent when the scan reaches the next dirty frame, the final
// one just after the pass.
// The walk speed is set by the single read and write port of the frame memory.
// Configuration goes through the APB port: frames_in_use at 0, policy at 4.
// Reset empties the table through valid bits held in flip-flops and clears the
// counters; frames_in_use resets to 16 and policy to FIFO.
module page_buffer_pool_replacement_top #(
	parameter int NUM_FRAMES = 16,
	parameter int PAGE_BITS  = 20,
	parameter int PIN_BITS   = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           op,
	input  logic [PAGE_BITS-1:0] page_number,
	input  logic [3:0]           frame_slot,
	output logic                 strobe,
	output logic [3:0]           frame_index,
	output logic                 hit,
	output logic [1:0]           status,
	output logic                 need_read,
	output logic                 write_back,
	output logic [PAGE_BITS-1:0] out_page,
	output logic                 out_valid,
	output logic                 out_dirty,
	output logic [7:0]           out_fix,
	output logic [31:0]          read_count,
	output logic [31:0]          write_count,
	output logic                 last,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import pbpr_pkg::*;

	localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int CW = $clog2(NUM_FRAMES + 1);
	localparam int AW = FW;
	localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};
	localparam logic [AW-1:0] AGE_MAX = AW'(NUM_FRAMES - 1);

	typedef struct packed {
		logic [PAGE_BITS-1:0] tag;
		logic                 dirty;
		logic [PIN_BITS-1:0]  pins;
		logic [AW-1:0]        rec;
		logic [AW-1:0]        arr;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_UPDATE, S_OUT
	} state_t;

	// frame memory and valid bits
	entry_t             mem [NUM_FRAMES];
	entry_t             rd_q;
	logic [NUM_FRAMES-1:0] valid_q;
	logic               we;
	logic [FW-1:0]      waddr, raddr;
	entry_t             wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	// configuration registers
	logic [4:0] frames_q;
	logic       policy_q;
	logic       cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= 5'd16;
			policy_q <= 1'b0;
		end else if (cfg_wr) begin
			if (paddr[2] == 1'b0) frames_q <= pwdata[4:0];
			else policy_q <= pwdata[0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr[2] == 1'b0) prdata[4:0] = frames_q;
		else prdata[0] = policy_q;
	end

	// frame limit: zero acts as one, above NUM_FRAMES as NUM_FRAMES
	logic [CW:0] lim;
	always_comb begin
		if (frames_q == 5'd0) lim = (CW+1)'(1);
		else if (32'(frames_q) > NUM_FRAMES) lim = (CW+1)'(NUM_FRAMES);
		else lim = (CW+1)'(frames_q);
	end

	// sequencer state
	state_t              state_q;
	logic [2:0]          op_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [3:0]          slot_q;
	logic [CW-1:0]       cnt_q;      // frame being issued
	logic                rv_q;       // read data valid this cycle
	logic [FW-1:0]       rfr_q;      // frame of rd_q
	logic                found_q;
	logic [FW-1:0]       fidx_q;
	entry_t              fent_q;
	logic                free_q;
	logic [FW-1:0]       free_idx_q;
	logic                vic_q;
	logic [FW-1:0]       vic_idx_q;
	logic [AW-1:0]       vic_age_q;
	entry_t              vent_q;
	logic                tgt_q;      // update target known
	logic [FW-1:0]       tgt_idx_q;
	logic                repl_q;
	logic [AW-1:0]       trec_q, tarr_q;
	logic [4:0]          nres_q;
	logic [FW-1:0]       fl_idx_q;   // flush write-back held until the next dirty frame
	logic [PAGE_BITS-1:0] fl_tag_q;
	logic [31:0]         miss_q, wcnt_q;

	assign busy = (state_q != S_IDLE);
	assign read_count = miss_q;
	assign write_count = wcnt_q;

	// read data seen as one frame
	logic      rvalid, rmatch, rin_lim;
	logic [AW-1:0] rage;
	assign rvalid  = valid_q[rfr_q];
	assign rmatch  = rvalid && (rd_q.tag == page_q);
	assign rin_lim = ({1'b0, CW'(rfr_q)} < lim);
	assign rage    = policy_q ? rd_q.rec : rd_q.arr;

	always_comb begin
		raddr = cnt_q[FW-1:0];
		we = 1'b0;
		waddr = rfr_q;
		wdata = rd_q;
		if (state_q == S_SCAN && rv_q && op_q == OP_FLUSH && rvalid && rd_q.dirty) begin
			we = 1'b1;
			wdata.dirty = 1'b0;
		end
		if (state_q == S_UPDATE && rv_q && tgt_q) begin
			if (rfr_q == tgt_idx_q) begin
				we = 1'b1;
				wdata.tag = page_q;
				wdata.dirty = 1'b0;
				wdata.pins = PIN_BITS'(1);
				wdata.rec = '0;
				wdata.arr = '0;
				if (!repl_q && found_q) begin
					wdata = fent_q;
					wdata.rec = '0;
					if (fent_q.pins != PIN_MAX) wdata.pins = fent_q.pins + 1'b1;
				end
			end else if (rvalid) begin
				we = 1'b1;
				if (found_q) begin
					if (rd_q.rec < trec_q) wdata.rec = rd_q.rec + 1'b1;
				end else if (repl_q) begin
					if (rd_q.rec < trec_q) wdata.rec = rd_q.rec + 1'b1;
					if (rd_q.arr < tarr_q) wdata.arr = rd_q.arr + 1'b1;
				end else begin
					if (rd_q.rec < AGE_MAX) wdata.rec = rd_q.rec + 1'b1;
					if (rd_q.arr < AGE_MAX) wdata.arr = rd_q.arr + 1'b1;
				end
			end
		end
		if (state_q == S_DECIDE && found_q) begin
			waddr = fidx_q;
			wdata = fent_q;
			case (op_q)
				OP_UNPIN: if (fent_q.pins != '0) begin
					we = 1'b1;
					wdata.pins = fent_q.pins - 1'b1;
					wdata.dirty = 1'b0;
				end
				OP_DIRTY: begin
					we = 1'b1;
					wdata.dirty = 1'b1;
				end
				OP_FORCE: begin
					we = 1'b1;
					wdata.dirty = 1'b0;
				end
				default: ;
			endcase
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			miss_q <= '0;
			wcnt_q <= '0;
			strobe <= 1'b0;
			cnt_q <= '0;
			rv_q <= 1'b0;
			last <= 1'b0;
			nres_q <= '0;
			op_q <= '0;
			found_q <= 1'b0;
			free_q <= 1'b0;
			vic_q <= 1'b0;
			tgt_q <= 1'b0;
			repl_q <= 1'b0;
		end else begin
			strobe <= 1'b0;
			rfr_q <= cnt_q[FW-1:0];
			case (state_q)
				S_IDLE: begin
					rv_q <= 1'b0;
					if (start) begin
						op_q <= op;
						page_q <= page_number;
						slot_q <= frame_slot;
						cnt_q <= '0;
						found_q <= 1'b0;
						free_q <= 1'b0;
						vic_q <= 1'b0;
						tgt_q <= 1'b0;
						nres_q <= '0;
						if (op == OP_INSPECT) begin
							cnt_q <= CW'(frame_slot[FW-1:0]);
							state_q <= S_OUT;
							rv_q <= 1'b0;
						end else if (op > OP_INSPECT) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_SCAN;
							rv_q <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					// issue next read, look at previous
					rv_q <= (32'(cnt_q) < NUM_FRAMES);
					if (32'(cnt_q) < NUM_FRAMES) cnt_q <= cnt_q + 1'b1;
					if (rv_q) begin
						if (rmatch && !found_q) begin
							found_q <= 1'b1;
							fidx_q <= rfr_q;
							fent_q <= rd_q;
						end
						if (!rvalid && rin_lim && !free_q) begin
							free_q <= 1'b1;
							free_idx_q <= rfr_q;
						end
						if (rvalid && rin_lim && rd_q.pins == '0 &&
							(!vic_q || rage > vic_age_q)) begin
							vic_q <= 1'b1;
							vic_idx_q <= rfr_q;
							vic_age_q <= rage;
							vent_q <= rd_q;
						end
						// send the held write-back, hold this one until the next is known
						if (op_q == OP_FLUSH && rvalid && rd_q.dirty && nres_q != 5'd16) begin
							if (nres_q != '0) begin
								strobe <= 1'b1;
								frame_index <= 4'(fl_idx_q);
								hit <= 1'b0;
								status <= ST_OK;
								need_read <= 1'b0;
								write_back <= 1'b1;
								out_page <= fl_tag_q;
								out_valid <= 1'b0;
								out_dirty <= 1'b0;
								out_fix <= '0;
								last <= 1'b0;
							end
							nres_q <= nres_q + 1'b1;
							fl_idx_q <= rfr_q;
							fl_tag_q <= rd_q.tag;
						end
						if (32'(rfr_q) == NUM_FRAMES - 1) begin
							rv_q <= 1'b0;
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					state_q <= S_OUT;
					rv_q <= 1'b0;
					if (op_q == OP_PIN) begin
						cnt_q <= '0;
						if (found_q) begin
							tgt_q <= 1'b1;
							tgt_idx_q <= fidx_q;
							trec_q <= fent_q.rec;
							repl_q <= 1'b0;
							state_q <= S_UPDATE;
						end else if (free_q) begin
							tgt_q <= 1'b1;
							tgt_idx_q <= free_idx_q;
							repl_q <= 1'b0;
							valid_q[free_idx_q] <= 1'b1;
							miss_q <= miss_q + 1'b1;
							state_q <= S_UPDATE;
						end else if (vic_q) begin
							tgt_q <= 1'b1;
							tgt_idx_q <= vic_idx_q;
							trec_q <= vent_q.rec;
							tarr_q <= vent_q.arr;
							repl_q <= 1'b1;
							miss_q <= miss_q + 1'b1;
							state_q <= S_UPDATE;
						end
					end else if (found_q && ((op_q == OP_UNPIN && fent_q.pins != '0 &&
							fent_q.dirty) || op_q == OP_FORCE)) begin
						wcnt_q <= wcnt_q + 1'b1;
					end
					// final flush write-back closes the item
					if (op_q == OP_FLUSH && nres_q != '0) begin
						state_q <= S_IDLE;
						strobe <= 1'b1;
						frame_index <= 4'(fl_idx_q);
						hit <= 1'b0;
						status <= ST_OK;
						need_read <= 1'b0;
						write_back <= 1'b1;
						out_page <= fl_tag_q;
						out_valid <= 1'b0;
						out_dirty <= 1'b0;
						out_fix <= '0;
						last <= 1'b1;
					end
				end
				S_UPDATE: begin
					rv_q <= (32'(cnt_q) < NUM_FRAMES);
					if (32'(cnt_q) < NUM_FRAMES) cnt_q <= cnt_q + 1'b1;
					if (rv_q && 32'(rfr_q) == NUM_FRAMES - 1) begin
						rv_q <= 1'b0;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// inspect waits in this state for its read data
					if (op_q == OP_INSPECT && !rv_q) begin
						rv_q <= 1'b1;
					end else begin
						state_q <= S_IDLE;
						strobe <= 1'b1;
						last <= 1'b1;
						frame_index <= '0;
						hit <= 1'b0;
						status <= ST_OK;
						need_read <= 1'b0;
						write_back <= 1'b0;
						out_page <= '0;
						out_valid <= 1'b0;
						out_dirty <= 1'b0;
						out_fix <= '0;
						case (op_q)
							OP_PIN: begin
								if (found_q) begin
									frame_index <= 4'(fidx_q);
									hit <= 1'b1;
								end else if (tgt_q) begin
									frame_index <= 4'(tgt_idx_q);
									need_read <= 1'b1;
									if (repl_q && vent_q.dirty) begin
										write_back <= 1'b1;
										out_page <= vent_q.tag;
									end
								end else status <= ST_ALL_PINNED;
							end
							OP_UNPIN, OP_DIRTY, OP_FORCE: begin
								if (!found_q) status <= ST_NOT_FOUND;
								else begin
									frame_index <= 4'(fidx_q);
									if (op_q == OP_UNPIN && fent_q.pins == '0)
										status <= ST_NOT_PINNED;
									else if ((op_q == OP_UNPIN && fent_q.dirty) ||
										op_q == OP_FORCE) begin
										write_back <= 1'b1;
										out_page <= page_q;
									end
								end
							end
							OP_INSPECT: begin
								frame_index <= slot_q;
								if (32'(slot_q) < NUM_FRAMES && valid_q[slot_q[FW-1:0]]) begin
									out_page <= rd_q.tag;
									out_valid <= 1'b1;
									out_dirty <= rd_q.dirty;
									out_fix <= 8'(rd_q.pins);
								end
							end
							default: ;
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/pbpr_checker.sv =====
// port-level checker for the page buffer pool replacement block
// bound to the top level; uses pbpr_pkg status codes
`timescale 1ns / 1ps
module pbpr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        strobe,
	input logic        last,
	input logic        hit,
	input logic        need_read,
	input logic [1:0]  status,
	input logic [31:0] read_count
);
	import pbpr_pkg::*;

	// an item is taken only when idle and then the block is busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("busy not raised");
	// a final result is shown while the block is idle
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> !busy) else $error("busy after last");
	// hit and read request never together
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !(hit && need_read)) else $error("hit with read");
	// a read request means the miss counter is not zero
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && need_read) |-> read_count != 32'd0) else $error("read count");
	// a read request comes with ok status
	a_st: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && need_read) |-> status == ST_OK) else $error("status");
endmodule

bind page_buffer_pool_replacement_top pbpr_checker u_pbpr_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .strobe(strobe),
	.last(last), .hit(hit), .need_read(need_read), .status(status),
	.read_count(read_count)
);
